[design/dsre_pkg.sv]
// types, codes and operator functions shared by the sequence range engine
package dsre_pkg;

  localparam int unsigned POS_W = 13;
  localparam int unsigned VAL_W = 64;
  localparam logic [VAL_W-1:0] MinIdentity = 64'd4000000000000000000;

  typedef enum logic [2:0] {
    MODE_SUM = 3'd0,
    MODE_MIN = 3'd1,
    MODE_XOR = 3'd2,
    MODE_OR  = 3'd3,
    MODE_AND = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_QUERY  = 3'd1,
    OP_APPLY  = 3'd2,
    OP_INSERT = 3'd3,
    OP_ERASE  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             set_en;
    logic             apply_en;
    logic             ins_en;
    logic             del_en;
    logic             query;
    mode_e            mode;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] val;
  } acc_t;

  function automatic logic [VAL_W-1:0] identity_of(mode_e m);
    logic [VAL_W-1:0] r;
    case (m)
      MODE_MIN: r = MinIdentity;
      MODE_AND: r = '1;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] combine(mode_e m, logic [VAL_W-1:0] a,
                                               logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] r;
    case (m)
      MODE_MIN: r = ($signed(a) < $signed(b)) ? a : b;
      MODE_XOR: r = a ^ b;
      MODE_OR:  r = a | b;
      MODE_AND: r = a & b;
      default:  r = a + b;
    endcase
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] apply_op(mode_e m, logic [VAL_W-1:0] v,
                                                logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] r;
    case (m)
      MODE_XOR: r = v ^ x;
      MODE_OR:  r = v | x;
      MODE_AND: r = v & x;
      default:  r = v + x;
    endcase
    return r;
  endfunction

endpackage

[design/dsre_cell.sv]
// one cell of the element row: holds one value, shifts, updates and folds the scan
module dsre_cell import dsre_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             exec_i,
  input  logic [VAL_W-1:0] prev_val_i,
  input  logic [VAL_W-1:0] next_val_i,
  input  acc_t             acc_i,
  output logic [VAL_W-1:0] val_o,
  output acc_t             acc_o
);

  localparam logic [POS_W-1:0] MyPos = POS_W'(INDEX + 1);

  logic [VAL_W-1:0] val_q, val_d;
  acc_t             acc_q, acc_d;
  logic             in_range;

  assign in_range = (MyPos >= ctrl_i.lo) && (MyPos <= ctrl_i.hi);

  always_comb begin
    val_d = val_q;
    if (exec_i) begin
      if (ctrl_i.set_en && MyPos == ctrl_i.pos) begin
        val_d = ctrl_i.value;
      end else if (ctrl_i.apply_en && in_range) begin
        val_d = apply_op(ctrl_i.mode, val_q, ctrl_i.value);
      end else if (ctrl_i.ins_en) begin
        if (MyPos == ctrl_i.pos) begin
          val_d = ctrl_i.value;
        end else if (MyPos > ctrl_i.pos) begin
          val_d = prev_val_i;
        end
      end else if (ctrl_i.del_en && MyPos >= ctrl_i.pos) begin
        val_d = next_val_i;
      end
    end
  end

  // running fold of the query range, one cell further each cycle
  always_comb begin
    acc_d.valid = acc_i.valid | in_range;
    if (acc_i.valid) begin
      acc_d.val = in_range ? combine(ctrl_i.mode, acc_i.val, val_q) : acc_i.val;
    end else begin
      acc_d.val = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    acc_q <= acc_d;
  end

  assign val_o = val_q;
  assign acc_o = acc_q;

endmodule

[design/dynamic_sequence_range_engine.sv]
// Dynamic sequence range engine: ordered store of 64-bit values with range ops.
//
// Requests enter on s_axis (tdata: operation, left_position, right_position,
// operand_value from bit 0 up); one result per request leaves on m_axis
// (tdata: aggregate, element_count, status from bit 0 up). The aggregate mode
// register is written over the APB port at address 0.
// The elements live in a row of CAPACITY cells. Set, apply, insert and erase
// act on every cell at once in the EXEC state, shifting through neighbors;
// such a request then passes to DONE, where the result register is loaded.
// A range query folds a partial aggregate down the row one cell per cycle
// in the SCAN state, which runs the length of the cell row before DONE.
// No new request is taken while one is in EXEC or SCAN.
// The result register parts the two sides: a new request is taken in the same
// cycle the previous result is loaded. While m_axis stalls with a result
// held, one more request finishes its work and then waits.
// Reset empties the store (count zero) and sets the mode to sum; element
// values are undefined until written and need no clearing.
module dynamic_sequence_range_engine import dsre_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // operation [2:0], left_position [11:3], right_position [20:12],
  // operand_value [84:21], zero fill above
  input  logic [87:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // aggregate [63:0], element_count [72:64], status [74:73], zero fill above
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SCAN_W = $clog2(CAPACITY);

  state_e              state_q, state_d;
  logic [2:0]          mode_q;
  mode_e               mode_eff;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SCAN_W-1:0]   scan_q, scan_d;
  cell_ctrl_t          ctrl_q, ctrl_d;
  status_e             status_q, status_d;
  logic                out_valid_q, out_valid_d;
  logic [VAL_W-1:0]    out_agg_q, out_agg_d;
  logic [8:0]          out_count_q, out_count_d;
  status_e             out_status_q, out_status_d;

  logic                accept, out_free, load_out, exec, scan_last;
  op_e                 in_op;
  logic [8:0]          in_lp, in_rp;
  logic [VAL_W-1:0]    in_val;
  logic [POS_W-1:0]    lp_w, rp_w, cnt_w;
  logic                pos_ok, full;

  logic [VAL_W-1:0]    row_val [CAPACITY];
  acc_t                row_acc [CAPACITY];

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 3'd0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      mode_q <= pwdata[2:0];
    end
  end

  always_comb begin
    case (mode_q)
      3'd1:    mode_eff = MODE_MIN;
      3'd2:    mode_eff = MODE_XOR;
      3'd3:    mode_eff = MODE_OR;
      3'd4:    mode_eff = MODE_AND;
      default: mode_eff = MODE_SUM;
    endcase
  end

  // request decode
  assign in_op  = op_e'(s_axis_tdata[2:0]);
  assign in_lp  = s_axis_tdata[11:3];
  assign in_rp  = s_axis_tdata[20:12];
  assign in_val = s_axis_tdata[84:21];
  assign lp_w   = POS_W'(in_lp);
  assign rp_w   = POS_W'(in_rp);
  assign cnt_w  = POS_W'(count_q);
  assign pos_ok = (lp_w != '0) && (lp_w <= cnt_w);
  assign full   = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    ctrl_d          = '0;
    ctrl_d.mode     = mode_eff;
    ctrl_d.value    = in_val;
    ctrl_d.pos      = lp_w;
    ctrl_d.lo       = (lp_w == '0) ? POS_W'(1) : lp_w;
    ctrl_d.hi       = (rp_w > cnt_w) ? cnt_w : rp_w;
    status_d        = ST_DONE;
    case (in_op)
      OP_SET: begin
        ctrl_d.set_en = pos_ok;
        status_d      = pos_ok ? ST_DONE : ST_IGNORED;
      end
      OP_QUERY: ctrl_d.query = 1'b1;
      OP_APPLY: ctrl_d.apply_en = 1'b1;
      OP_INSERT: begin
        ctrl_d.ins_en = !full;
        status_d      = full ? ST_FULL : ST_DONE;
        if (lp_w == '0) begin
          ctrl_d.pos = POS_W'(1);
        end else if (lp_w > cnt_w + POS_W'(1)) begin
          ctrl_d.pos = cnt_w + POS_W'(1);
        end
      end
      OP_ERASE: begin
        ctrl_d.del_en = pos_ok;
        status_d      = pos_ok ? ST_DONE : ST_IGNORED;
      end
      default: status_d = ST_IGNORED;
    endcase
  end

  // sequencer
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) || (state_q == S_DONE && out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign scan_last     = (scan_q == SCAN_W'(CAPACITY - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_op == OP_QUERY) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: state_d = S_DONE;
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (accept) begin
          state_d = (in_op == OP_QUERY) ? S_SCAN : S_EXEC;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    exec     = (state_q == S_EXEC);
    load_out = (state_q == S_DONE) && out_free;
    scan_d   = accept ? '0 : ((state_q == S_SCAN) ? scan_q + SCAN_W'(1) : scan_q);
    count_d  = count_q;
    if (exec && ctrl_q.ins_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (exec && ctrl_q.del_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // result register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_agg_d    = out_agg_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    if (load_out) begin
      out_valid_d  = 1'b1;
      out_count_d  = 9'(count_q);
      out_status_d = status_q;
      if (!ctrl_q.query) begin
        out_agg_d = '0;
      end else if (row_acc[CAPACITY-1].valid) begin
        out_agg_d = row_acc[CAPACITY-1].val;
      end else begin
        out_agg_d = identity_of(ctrl_q.mode);
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      ctrl_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        ctrl_q <= ctrl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
    out_agg_q    <= out_agg_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_status_q, out_count_q, out_agg_q};

  // cell row
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VAL_W-1:0] prev_val, next_val;
    acc_t             prev_acc;

    if (k == 0) begin : g_head
      assign prev_val = '0;
      assign prev_acc = '0;
    end else begin : g_body
      assign prev_val = row_val[k-1];
      assign prev_acc = row_acc[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign next_val = row_val[k];
    end else begin : g_inner
      assign next_val = row_val[k+1];
    end

    dsre_cell #(
      .INDEX(k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_q),
      .exec_i     (exec),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .acc_i      (prev_acc),
      .val_o      (row_val[k]),
      .acc_o      (row_acc[k])
    );
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC || state_q == S_SCAN) |-> !s_axis_tready)
    else $error("request taken while busy");

  a_count_only_on_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EXEC || (!ctrl_q.ins_en && !ctrl_q.del_en)) |=> $stable(count_q))
    else $error("count changed without insert or erase");

  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !ctrl_q.query) |=> (out_agg_q == '0))
    else $error("nonzero aggregate on update request");
`endif

endmodule
